// ===== rtl/core/rgsf_pkg.sv =====
// Shared constants, types and helpers for the RGB gradient span fill core.
`default_nettype none
package rgsf_pkg;

    localparam int PALETTE_SIZE = 64;

    localparam int POS_W   = 6;
    localparam int COLOR_W = 8;
    localparam int ACC_W   = 16;
    localparam int FRAC_W  = 7;
    localparam int NUM_CH  = 3;

    // Dividend is |end - start| << 7, which fits in 15 bits.
    localparam int DVD_W      = COLOR_W + FRAC_W;
    localparam int DIV_STEPS  = DVD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int POS_TOP_INT = (PALETTE_SIZE - 1 > 63) ? 63 : PALETTE_SIZE - 1;
    localparam logic [POS_W-1:0] POS_TOP = POS_W'(POS_TOP_INT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_LATCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic latch_steps;
        logic advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic at_last;
    } dp_status_t;

    function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p);
        return (p > POS_TOP) ? POS_TOP : p;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rgsf_div.sv =====
// One restoring divider lane: one quotient bit per cycle while step is high, signed step output.
`default_nettype none
module rgsf_div (
    input  wire logic                          aclk,
    input  wire logic                          start,
    input  wire logic                          step,
    input  wire logic [rgsf_pkg::DVD_W-1:0]    dividend,
    input  wire logic                          negative,
    input  wire logic [rgsf_pkg::POS_W-1:0]    divisor,
    output logic      [rgsf_pkg::ACC_W-1:0]    step_value
);

    logic [rgsf_pkg::POS_W-1:0] rem_reg,  rem_next;
    logic [rgsf_pkg::DVD_W-1:0] quo_reg,  quo_next;
    logic                       neg_reg,  neg_next;
    logic [rgsf_pkg::POS_W:0]   trial;
    logic [rgsf_pkg::POS_W:0]   diff;
    logic [rgsf_pkg::ACC_W-1:0] doubled;

    assign trial = {rem_reg, quo_reg[rgsf_pkg::DVD_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        neg_next = neg_reg;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            neg_next = negative;
        end else if (step) begin
            // Restore unless the shifted remainder covers the divisor.
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[rgsf_pkg::POS_W-1:0];
                quo_next = {quo_reg[rgsf_pkg::DVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[rgsf_pkg::POS_W-1:0];
                quo_next = {quo_reg[rgsf_pkg::DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    // Double the magnitude, then apply the sign; all modulo 2^16.
    assign doubled    = rgsf_pkg::ACC_W'({quo_reg, 1'b0});
    assign step_value = neg_reg ? (~doubled + rgsf_pkg::ACC_W'(1)) : doubled;

endmodule
`default_nettype wire

// ===== rtl/core/rgsf_ctrl.sv =====
// Controller state machine: accept, divide, latch steps, emit pixels.
`default_nettype none
module rgsf_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    input  wire rgsf_pkg::dp_status_t   status,
    output rgsf_pkg::ctrl_cmd_t         cmd
);

    rgsf_pkg::state_t                 state_reg, state_next;
    logic [rgsf_pkg::DIV_CNT_W-1:0]   count_reg, count_next;
    logic                             div_done;

    assign div_done = (count_reg == rgsf_pkg::DIV_CNT_W'(rgsf_pkg::DIV_STEPS - 1));

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            rgsf_pkg::ST_IDLE: begin
                count_next = '0;
                if (s_valid) begin
                    state_next = rgsf_pkg::ST_DIVIDE;
                end
            end
            rgsf_pkg::ST_DIVIDE: begin
                count_next = count_reg + rgsf_pkg::DIV_CNT_W'(1);
                if (div_done) begin
                    state_next = rgsf_pkg::ST_LATCH;
                end
            end
            rgsf_pkg::ST_LATCH: begin
                state_next = rgsf_pkg::ST_EMIT;
            end
            rgsf_pkg::ST_EMIT: begin
                if (m_ready && status.at_last) begin
                    state_next = rgsf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rgsf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            rgsf_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            rgsf_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            rgsf_pkg::ST_LATCH: begin
                cmd.latch_steps = 1'b1;
            end
            rgsf_pkg::ST_EMIT: begin
                m_valid     = 1'b1;
                cmd.advance = m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rgsf_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rgsf_dp.sv =====
// Datapath: endpoint ordering, step dividers, accumulators and pixel position.
`default_nettype none
module rgsf_dp (
    input  wire logic                              aclk,
    input  wire rgsf_pkg::ctrl_cmd_t               cmd,
    output rgsf_pkg::dp_status_t                   status,
    input  wire logic [rgsf_pkg::POS_W-1:0]        s_start_pos,
    input  wire logic [rgsf_pkg::POS_W-1:0]        s_end_pos,
    input  wire logic [rgsf_pkg::COLOR_W-1:0]      s_start_red,
    input  wire logic [rgsf_pkg::COLOR_W-1:0]      s_start_green,
    input  wire logic [rgsf_pkg::COLOR_W-1:0]      s_start_blue,
    input  wire logic [rgsf_pkg::COLOR_W-1:0]      s_end_red,
    input  wire logic [rgsf_pkg::COLOR_W-1:0]      s_end_green,
    input  wire logic [rgsf_pkg::COLOR_W-1:0]      s_end_blue,
    output logic      [rgsf_pkg::POS_W-1:0]        m_pixel_index,
    output logic      [rgsf_pkg::COLOR_W-1:0]      m_red,
    output logic      [rgsf_pkg::COLOR_W-1:0]      m_green,
    output logic      [rgsf_pkg::COLOR_W-1:0]      m_blue,
    output logic                                   m_last
);

    logic [rgsf_pkg::POS_W-1:0]   pos_a, pos_b, lo_pos, hi_pos;
    logic                         swap;
    logic [rgsf_pkg::POS_W-1:0]   divisor_in;
    logic [rgsf_pkg::COLOR_W-1:0] c_start [rgsf_pkg::NUM_CH];
    logic [rgsf_pkg::COLOR_W-1:0] c_end   [rgsf_pkg::NUM_CH];
    logic [rgsf_pkg::COLOR_W-1:0] c_lo    [rgsf_pkg::NUM_CH];
    logic [rgsf_pkg::COLOR_W-1:0] c_hi    [rgsf_pkg::NUM_CH];
    logic [rgsf_pkg::DVD_W-1:0]   dvd     [rgsf_pkg::NUM_CH];
    logic                         neg     [rgsf_pkg::NUM_CH];
    logic [rgsf_pkg::ACC_W-1:0]   lane_step [rgsf_pkg::NUM_CH];

    logic [rgsf_pkg::POS_W-1:0]   cur_pos_reg, cur_pos_next;
    logic [rgsf_pkg::POS_W-1:0]   fin_pos_reg, fin_pos_next;
    logic [rgsf_pkg::POS_W-1:0]   divisor_reg, divisor_next;
    logic [rgsf_pkg::ACC_W-1:0]   acc_reg  [rgsf_pkg::NUM_CH];
    logic [rgsf_pkg::ACC_W-1:0]   acc_next [rgsf_pkg::NUM_CH];
    logic [rgsf_pkg::ACC_W-1:0]   step_reg  [rgsf_pkg::NUM_CH];
    logic [rgsf_pkg::ACC_W-1:0]   step_next [rgsf_pkg::NUM_CH];

    assign pos_a = rgsf_pkg::clamp_pos(s_start_pos);
    assign pos_b = rgsf_pkg::clamp_pos(s_end_pos);
    assign swap  = (pos_b < pos_a);
    assign lo_pos = swap ? pos_b : pos_a;
    assign hi_pos = swap ? pos_a : pos_b;
    // Equal endpoints divide by one.
    assign divisor_in = (hi_pos > lo_pos) ? (hi_pos - lo_pos) : rgsf_pkg::POS_W'(1);

    assign c_start[0] = s_start_red;
    assign c_start[1] = s_start_green;
    assign c_start[2] = s_start_blue;
    assign c_end[0]   = s_end_red;
    assign c_end[1]   = s_end_green;
    assign c_end[2]   = s_end_blue;

    for (genvar k = 0; k < rgsf_pkg::NUM_CH; k++) begin : g_lane
        logic [rgsf_pkg::COLOR_W-1:0] mag;

        assign c_lo[k] = swap ? c_end[k]   : c_start[k];
        assign c_hi[k] = swap ? c_start[k] : c_end[k];
        assign neg[k]  = (c_hi[k] < c_lo[k]);
        assign mag     = neg[k] ? (c_lo[k] - c_hi[k]) : (c_hi[k] - c_lo[k]);
        assign dvd[k]  = {mag, {rgsf_pkg::FRAC_W{1'b0}}};

        rgsf_div u_div (
            .aclk       (aclk),
            .start      (cmd.load),
            .step       (cmd.div_step),
            .dividend   (dvd[k]),
            .negative   (neg[k]),
            .divisor    (divisor_reg),
            .step_value (lane_step[k])
        );
    end

    always_comb begin
        cur_pos_next = cur_pos_reg;
        fin_pos_next = fin_pos_reg;
        divisor_next = divisor_reg;
        for (int k = 0; k < rgsf_pkg::NUM_CH; k++) begin
            acc_next[k]  = acc_reg[k];
            step_next[k] = step_reg[k];
        end
        if (cmd.load) begin
            cur_pos_next = lo_pos;
            fin_pos_next = hi_pos;
            divisor_next = divisor_in;
            for (int k = 0; k < rgsf_pkg::NUM_CH; k++) begin
                acc_next[k] = {c_lo[k], {(rgsf_pkg::ACC_W - rgsf_pkg::COLOR_W){1'b0}}};
            end
        end
        if (cmd.latch_steps) begin
            for (int k = 0; k < rgsf_pkg::NUM_CH; k++) begin
                step_next[k] = lane_step[k];
            end
        end
        if (cmd.advance) begin
            // Hold the position on the final pixel; accumulators still add.
            if (!status.at_last) begin
                cur_pos_next = cur_pos_reg + rgsf_pkg::POS_W'(1);
            end
            for (int k = 0; k < rgsf_pkg::NUM_CH; k++) begin
                acc_next[k] = acc_reg[k] + step_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_pos_reg <= cur_pos_next;
        fin_pos_reg <= fin_pos_next;
        divisor_reg <= divisor_next;
        for (int k = 0; k < rgsf_pkg::NUM_CH; k++) begin
            acc_reg[k]  <= acc_next[k];
            step_reg[k] <= step_next[k];
        end
    end

    assign status.at_last = (cur_pos_reg == fin_pos_reg);

    assign m_pixel_index = cur_pos_reg;
    assign m_red   = acc_reg[0][rgsf_pkg::ACC_W-1 -: rgsf_pkg::COLOR_W];
    assign m_green = acc_reg[1][rgsf_pkg::ACC_W-1 -: rgsf_pkg::COLOR_W];
    assign m_blue  = acc_reg[2][rgsf_pkg::ACC_W-1 -: rgsf_pkg::COLOR_W];
    assign m_last  = status.at_last;

endmodule
`default_nettype wire

// ===== rtl/core/rgb_gradient_span_fill_core.sv =====
// An accepted request passes through the divide state, then the latch state, before its first pixel.
// A span holds N pixels (1..64); after the bit-serial step dividers finish, the pixels
//   follow at one per cycle while m_ready is high.
// One request at a time; s_ready is high only while no span is in flight.
// Reset: synchronous active-low aresetn returns the controller to idle; the
//   datapath registers are loaded by each request and need no reset.
`default_nettype none
module rgb_gradient_span_fill_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Request channel: two endpoints with their colors.
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [rgsf_pkg::POS_W-1:0]    s_start_pos,
    input  wire logic [rgsf_pkg::POS_W-1:0]    s_end_pos,
    input  wire logic [rgsf_pkg::COLOR_W-1:0]  s_start_red,
    input  wire logic [rgsf_pkg::COLOR_W-1:0]  s_start_green,
    input  wire logic [rgsf_pkg::COLOR_W-1:0]  s_start_blue,
    input  wire logic [rgsf_pkg::COLOR_W-1:0]  s_end_red,
    input  wire logic [rgsf_pkg::COLOR_W-1:0]  s_end_green,
    input  wire logic [rgsf_pkg::COLOR_W-1:0]  s_end_blue,
    // Pixel channel: one interpolated color per palette position.
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [rgsf_pkg::POS_W-1:0]    m_pixel_index,
    output logic      [rgsf_pkg::COLOR_W-1:0]  m_red,
    output logic      [rgsf_pkg::COLOR_W-1:0]  m_green,
    output logic      [rgsf_pkg::COLOR_W-1:0]  m_blue,
    output logic                               m_last
);

    // Commands from the controller, status back from the datapath.
    rgsf_pkg::ctrl_cmd_t  cmd;
    rgsf_pkg::dp_status_t status;

    // Controller: sequences accept, the three parallel divisions, the step
    // latch and the pixel stream; the pixel registers hold while m_ready is low.
    rgsf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: orders the endpoints, divides each color swing into an unsigned
    // 8.7 step, doubles and signs it, and walks the 8.8 accumulators across the span.
    rgsf_dp u_dp (
        .aclk          (aclk),
        .cmd           (cmd),
        .status        (status),
        .s_start_pos   (s_start_pos),
        .s_end_pos     (s_end_pos),
        .s_start_red   (s_start_red),
        .s_start_green (s_start_green),
        .s_start_blue  (s_start_blue),
        .s_end_red     (s_end_red),
        .s_end_green   (s_end_green),
        .s_end_blue    (s_end_blue),
        .m_pixel_index (m_pixel_index),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire
